@@ rtl/core/pfl_pkg.sv @@
`timescale 1ns / 1ps

package pfl_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_REFERENCE = 3'd0,
    REG_FEEDBACK  = 3'd1,
    REG_PROP      = 3'd2,
    REG_INT       = 3'd3,
    REG_DPOLE     = 3'd4,
    REG_DGAIN     = 3'd5,
    REG_WINDUP    = 3'd6,
    REG_PLANT     = 3'd7
  } reg_idx_t;

  localparam logic signed [31:0] SAT_MAX       = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN       = 32'sh8000_0000;
  // Full duty (4096.0) in Q16.16.
  localparam logic signed [31:0] FULL_DUTY_RAW = 32'sh1000_0000;
  localparam logic [30:0]        PLANT_RESET   = 31'd65536;

  // Wide working width for sums and shifted products.
  localparam int WIDE_W = 50;

  function automatic logic signed [WIDE_W-1:0] sx32(input logic signed [31:0] v);
    return {{(WIDE_W-32){v[31]}}, v};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [31:0] r;
    if (v > sx32(SAT_MAX)) begin
      r = SAT_MAX;
    end else if (v < sx32(SAT_MIN)) begin
      r = SAT_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/pfl_mul.sv @@
`timescale 1ns / 1ps

// Shared signed multiplier with a registered product.
module pfl_mul (
  input  logic               clk,
  input  logic signed [32:0] op_a,
  input  logic signed [32:0] op_b,
  output logic signed [65:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

@@ rtl/core/pfl_div.sv @@
`timescale 1ns / 1ps

// Feedforward quotient: reference * 2^28 / plant, truncated toward zero and
// saturated to 32 bits. Restoring division, one quotient bit per cycle.
module pfl_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] dividend,
  input  logic [30:0]        divisor,
  output logic signed [31:0] quotient_r,
  output logic               done_r
);

  logic        run_r;
  logic        neg_r;
  logic [4:0]  cnt_r;
  logic [31:0] rem_r;
  logic [30:0] sh_r;
  logic [30:0] quo_r;

  logic [31:0] mag;
  logic        ovf;
  logic [31:0] trial;
  logic        ge;
  logic [30:0] quo_nxt;

  assign mag     = dividend[31] ? (~dividend + 32'd1) : dividend;
  // The quotient magnitude reaches 2^31 exactly when |ref| >= 8 * plant.
  assign ovf     = {2'b00, mag} >= {divisor, 3'b000};
  assign trial   = {rem_r[30:0], sh_r[30]};
  assign ge      = trial >= {1'b0, divisor};
  assign quo_nxt = {quo_r[29:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      neg_r <= dividend[31];
      rem_r <= {3'b000, mag[31:3]};
      sh_r  <= {mag[2:0], 28'd0};
      quo_r <= '0;
      cnt_r <= 5'd30;
      if (dividend == 32'sd0) begin
        quotient_r <= 32'sd0;
        run_r      <= 1'b0;
        done_r     <= 1'b1;
      end else if (ovf) begin
        quotient_r <= dividend[31] ? pfl_pkg::SAT_MIN : pfl_pkg::SAT_MAX;
        run_r      <= 1'b0;
        done_r     <= 1'b1;
      end else begin
        run_r  <= 1'b1;
        done_r <= 1'b0;
      end
    end else if (run_r) begin
      rem_r <= ge ? (trial - {1'b0, divisor}) : trial;
      sh_r  <= {sh_r[29:0], 1'b0};
      quo_r <= quo_nxt;
      cnt_r <= cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        quotient_r <= neg_r ? -$signed({1'b0, quo_nxt}) : $signed({1'b0, quo_nxt});
        run_r      <= 1'b0;
        done_r     <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/pid_feedforward_light_controller.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Ports                                   Handshake
// in       input      in_measured_lux                         in_valid / in_ready
// out      output     out_duty_count, out_external_lux        out_valid / out_ready
// cfg      input      cfg_index, cfg_wdata                    cfg_wr_en, no wait
//
// A word reaches out_valid once the bit-serial feedforward divider (31 steps) is
// done; the six products share one multiplier meanwhile. A zero or saturated
// quotient skips the divider. in_ready returns the cycle after the result word
// is taken, so no new word is accepted while one is in flight, and a low
// out_ready holds both the result and the input.
// Reset is synchronous, restores the configuration defaults and clears the state.
module pid_feedforward_light_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_measured_lux,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_duty_count,
  output logic signed [31:0] out_external_lux,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_MINT   = 12'b0000_0000_0010,
    S_MWIND  = 12'b0000_0000_0100,
    S_MPLANT = 12'b0000_0000_1000,
    S_MPROP  = 12'b0000_0001_0000,
    S_MPOLE  = 12'b0000_0010_0000,
    S_MGAIN  = 12'b0000_0100_0000,
    S_MLAST  = 12'b0000_1000_0000,
    S_WDIV   = 12'b0001_0000_0000,
    S_SUM    = 12'b0010_0000_0000,
    S_OUT    = 12'b0100_0000_0000,
    S_SPARE  = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration.
  logic signed [31:0] ref_r, prop_r, igain_r, pole_r, dgain_r, wgain_r;
  logic               fb_on_r;
  logic [30:0]        plant_r;

  // Controller state.
  logic signed [31:0] integ_r, deriv_r, prev_r, raw_r, clamp_r;

  // Per-word working registers.
  logic signed [31:0] y_r, err_r, derr_r, dy_r, q1_r, ext_r, p_r, da_r, v_r;
  logic signed [31:0] duty_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [31:0] prod_q;
  logic signed [pfl_pkg::WIDE_W-1:0] plant_term;
  logic signed [31:0] ff_q;
  logic               div_done;
  logic               accept;
  logic signed [31:0] v_fb;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign accept    = in_valid && in_ready;
  assign out_duty_count   = duty_r;
  assign out_external_lux = ext_r;

  pfl_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod)
  );

  pfl_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (accept),
    .dividend   (ref_r),
    .divisor    (plant_r),
    .quotient_r (ff_q),
    .done_r     (div_done)
  );

  // Q16.16 product, floored and saturated.
  assign prod_q     = pfl_pkg::sat32(prod[65:16]);
  assign plant_term = {{(pfl_pkg::WIDE_W-38){prod[65]}}, prod[65:28]};
  assign v_fb = pfl_pkg::sat32(pfl_pkg::sx32(v_r) + pfl_pkg::sx32(p_r)
                               + pfl_pkg::sx32(integ_r) + pfl_pkg::sx32(deriv_r));

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MINT: begin
        mul_a = {igain_r[31], igain_r};
        mul_b = {err_r[31], err_r};
      end
      S_MWIND: begin
        mul_a = {wgain_r[31], wgain_r};
        mul_b = {derr_r[31], derr_r};
      end
      S_MPLANT: begin
        mul_a = {2'b00, plant_r};
        mul_b = {clamp_r[31], clamp_r};
      end
      S_MPROP: begin
        mul_a = {prop_r[31], prop_r};
        mul_b = {err_r[31], err_r};
      end
      S_MPOLE: begin
        mul_a = {pole_r[31], pole_r};
        mul_b = {deriv_r[31], deriv_r};
      end
      S_MGAIN: begin
        mul_a = {dgain_r[31], dgain_r};
        mul_b = {dy_r[31], dy_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) begin
                  state_nxt = S_MINT;
                end
      S_MINT:   state_nxt = S_MWIND;
      S_MWIND:  state_nxt = S_MPLANT;
      S_MPLANT: state_nxt = S_MPROP;
      S_MPROP:  state_nxt = S_MPOLE;
      S_MPOLE:  state_nxt = S_MGAIN;
      S_MGAIN:  state_nxt = S_MLAST;
      S_MLAST:  state_nxt = S_WDIV;
      S_WDIV:   if (div_done) begin
                  state_nxt = S_SUM;
                end
      S_SUM:    state_nxt = S_OUT;
      S_OUT:    if (out_ready) begin
                  state_nxt = S_IDLE;
                end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r   <= '0;
      fb_on_r <= 1'b1;
      prop_r  <= '0;
      igain_r <= '0;
      pole_r  <= '0;
      dgain_r <= '0;
      wgain_r <= '0;
      plant_r <= pfl_pkg::PLANT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        pfl_pkg::REG_REFERENCE: ref_r   <= cfg_wdata;
        pfl_pkg::REG_FEEDBACK:  fb_on_r <= cfg_wdata[0];
        pfl_pkg::REG_PROP:      prop_r  <= cfg_wdata;
        pfl_pkg::REG_INT:       igain_r <= cfg_wdata;
        pfl_pkg::REG_DPOLE:     pole_r  <= cfg_wdata;
        pfl_pkg::REG_DGAIN:     dgain_r <= cfg_wdata;
        pfl_pkg::REG_WINDUP:    wgain_r <= cfg_wdata;
        pfl_pkg::REG_PLANT:     plant_r <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // Controller state lives across words and follows the reset values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      deriv_r <= '0;
      prev_r  <= '0;
      raw_r   <= '0;
      clamp_r <= '0;
    end else begin
      if (state_r == S_MPLANT) begin
        integ_r <= pfl_pkg::sat32(pfl_pkg::sx32(integ_r) + pfl_pkg::sx32(q1_r)
                                  + pfl_pkg::sx32(prod_q));
      end
      if (state_r == S_MLAST && fb_on_r) begin
        deriv_r <= pfl_pkg::sat32(pfl_pkg::sx32(da_r) - pfl_pkg::sx32(prod_q));
      end
      if (state_r == S_SUM) begin
        prev_r <= y_r;
        if (fb_on_r) begin
          raw_r <= v_fb;
          if (v_fb < 32'sd0) begin
            clamp_r <= 32'sd0;
          end else if (v_fb > pfl_pkg::FULL_DUTY_RAW) begin
            clamp_r <= pfl_pkg::FULL_DUTY_RAW;
          end else begin
            clamp_r <= v_fb;
          end
        end else begin
          raw_r   <= v_r;
          clamp_r <= v_r;
        end
      end
    end
  end

  // Working values; the derivative uses the sample of the previous word.
  always_ff @(posedge clk) begin
    if (accept) begin
      y_r    <= in_measured_lux;
      err_r  <= pfl_pkg::sat32(pfl_pkg::sx32(ref_r) - pfl_pkg::sx32(in_measured_lux));
      derr_r <= pfl_pkg::sat32(pfl_pkg::sx32(clamp_r) - pfl_pkg::sx32(raw_r));
      dy_r   <= pfl_pkg::sat32(pfl_pkg::sx32(in_measured_lux) - pfl_pkg::sx32(prev_r));
    end
    if (state_r == S_MWIND) begin
      q1_r <= prod_q;
    end
    if (state_r == S_MPROP) begin
      ext_r <= pfl_pkg::sat32(pfl_pkg::sx32(y_r) - plant_term);
    end
    if (state_r == S_MPOLE) begin
      p_r <= prod_q;
    end
    if (state_r == S_MGAIN) begin
      da_r <= prod_q;
    end
    if (state_r == S_WDIV && div_done) begin
      v_r <= pfl_pkg::sat32(pfl_pkg::sx32(ff_q) - pfl_pkg::sx32(ext_r));
    end
    if (state_r == S_SUM) begin
      if (fb_on_r) begin
        if (v_fb < 32'sd0) begin
          duty_r <= 32'sd0;
        end else if (v_fb > pfl_pkg::FULL_DUTY_RAW) begin
          duty_r <= pfl_pkg::FULL_DUTY_RAW;
        end else begin
          duty_r <= v_fb;
        end
      end else begin
        duty_r <= v_r;
      end
    end
  end

endmodule
